// ===== design/unordered_key_list_engine_defines.svh =====
// Assertion macros for the unordered key list engine.
`ifndef UNORDERED_KEY_LIST_ENGINE_DEFINES_SVH
`define UNORDERED_KEY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define UKLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define UKLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ukle_pkg.sv =====
// Shared constants and types for the unordered key list engine.
package ukle_pkg;

  localparam int LIST_SIZE   = 32;
  localparam int IDX_W       = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int CNT_W       = $clog2(LIST_SIZE + 1);

  localparam int FUNC_W      = 2;
  localparam int KEY_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 5;
  localparam int COUNT_W     = 6;
  localparam int OUT_TDATA_W = ((POS_W + COUNT_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic REMOVE_SWAP = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_EXEC   = 6'b000100,
    S_SWAP   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_RESULT = 6'b100000
  } seq_state_t;

endpackage

// ===== design/unordered_key_list_engine.sv =====
// Unordered key list with linear search, held in one synchronous key memory.
//
//   channel | ports         | payload
//   --------+---------------+---------------------------------------------
//   input   | in_t*         | tuser: func[1:0]; tdata: key[31:0]
//   result  | out_t*        | tuser: status[1:0]; tdata: position[4:0],
//           |               |        entry_count[10:5], zero pad [15:11]
//   config  | cfg_*         | data: remove_mode[0]
//
// An item passes from accept to the search, which compares keys in turn (up to the
// occupancy, one memory read per cycle) until a match, then to execute, then to a swap
// step for a swap removal or a shift step moving the later entries for a shift removal.
// The key memory has a single read and a single write port.
// Reset clears the occupancy, the remove mode and the sequencer; keys need no clearing.
// A result waits in the output register; a new beat is taken while it waits, and
// the sequencer stalls before loading its own result until that register frees.
`include "unordered_key_list_engine_defines.svh"

module unordered_key_list_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ukle_pkg::KEY_W-1:0]       in_tdata,   // key
  input  logic [ukle_pkg::FUNC_W-1:0]      in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ukle_pkg::OUT_TDATA_W-1:0] out_tdata,  // position, entry_count, pad
  output logic [ukle_pkg::STATUS_W-1:0]    out_tuser,  // status
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data    // remove_mode
);
  import ukle_pkg::*;

  logic [KEY_W-1:0] key_mem [LIST_SIZE];
  logic [KEY_W-1:0] rdata_r;

  seq_state_t          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic                mode_r;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    hit_r, hit_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             issue;
  logic [CNT_W-1:0] occ_m1;
  logic [IDX_W-1:0] last_idx;
  logic             out_free;

  assign issue     = (scan_r < occ_r);
  assign occ_m1    = occ_r - CNT_W'(1);
  assign last_idx  = occ_m1[IDX_W-1:0];
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - POS_W - COUNT_W){1'b0}}, out_cnt_r, out_pos_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= key_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    occ_nxt        = occ_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    rd_en          = 1'b0;
    rd_addr        = scan_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = hit_r;
    wr_data        = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt    = in_tuser;
          key_nxt     = in_tdata;
          found_nxt   = 1'b0;
          scan_nxt    = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (issue) begin
          rd_en       = 1'b1;
          scan_nxt    = scan_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r && (rdata_r == key_r)) begin
          found_nxt   = 1'b1;
          hit_nxt     = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end else if (!issue) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        pos_nxt    = '0;
        state_nxt  = S_RESULT;
        case (func_r)
          FN_INSERT: begin
            if (found_r) begin
              status_nxt = ST_DUP;
            end else if (occ_r == CNT_W'(LIST_SIZE)) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = occ_r[IDX_W-1:0];
              wr_data = key_r;
              pos_nxt = occ_r[IDX_W-1:0];
              occ_nxt = occ_r + CNT_W'(1);
            end
          end
          FN_LOOKUP: begin
            if (found_r) begin
              pos_nxt = hit_r;
            end else begin
              status_nxt = ST_NOTFOUND;
            end
          end
          FN_REMOVE: begin
            if (found_r) begin
              pos_nxt = hit_r;
              if (mode_r == REMOVE_SWAP) begin
                rd_en     = 1'b1;
                rd_addr   = last_idx;
                state_nxt = S_SWAP;
              end else begin
                scan_nxt    = CNT_W'(hit_r) + CNT_W'(1);
                cmp_vld_nxt = 1'b0;
                state_nxt   = S_SHIFT;
              end
            end else begin
              status_nxt = ST_NOTFOUND;
            end
          end
          default: begin
            status_nxt = ST_NOTFOUND;
          end
        endcase
      end
      S_SWAP: begin
        wr_en     = 1'b1;
        wr_addr   = hit_r;
        wr_data   = rdata_r;
        occ_nxt   = occ_m1;
        state_nxt = S_RESULT;
      end
      S_SHIFT: begin
        if (issue) begin
          rd_en       = 1'b1;
          scan_nxt    = scan_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0] - IDX_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          occ_nxt     = occ_m1;
          state_nxt   = S_RESULT;
        end
        if (cmp_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx_r;
          wr_data = rdata_r;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_pos_nxt    = POS_W'(pos_r);
          out_cnt_nxt    = COUNT_W'(occ_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      mode_r       <= REMOVE_SWAP;
      cmp_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    status_r     <= status_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  `UKLE_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= CNT_W'(LIST_SIZE), "Occupancy exceeds list size.")
  `UKLE_ASSERT_NOW(a_pos_zero, out_tvalid_r && (out_status_r != ST_OK), out_pos_r == '0, "Position not zero on a failed operation.")
  `UKLE_ASSERT_NEXT(a_occ_step, 1'b1, $stable(occ_r) || (occ_r == $past(occ_r) + CNT_W'(1)) || (occ_r == $past(occ_r) - CNT_W'(1)), "Occupancy moved by more than one.")
  `UKLE_ASSERT_NEXT(a_load_src, !out_tvalid_r && (state_r != S_RESULT), !out_tvalid_r, "Result beat raised outside the result state.")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the unordered key list engine with a built-in list predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ukle_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS = 240;
  localparam int POOL_SIZE = 40;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
  } result_t;

  typedef struct {
    int                mode;
    bit                fill;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                typed;
    result_t           res;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [KEY_W-1:0] in_tdata;
  logic [FUNC_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  logic [KEY_W-1:0] held_keys [LIST_SIZE];
  int held_count;
  logic remove_mode_q;

  result_t expected_results [$];
  step_t steps [DIRECTED_ROWS];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int requests_sent;
  int status_seen [4];
  int idle_cycles;

  always #5ns clk = ~clk;

  unordered_key_list_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic bit locate_key(input logic [KEY_W-1:0] k, output int pos);
    pos = 0;
    for (int i = 0; i < held_count; i++) begin
      if (held_keys[i] == k) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t apply_list_op(input logic [FUNC_W-1:0] fn,
                                            input logic [KEY_W-1:0] k);
    result_t r;
    int hit;
    bit found;
    found = locate_key(k, hit);
    r = '{ST_OK, '0, '0};
    case (fn)
      FN_INSERT: begin
        if (found) begin
          r.status = ST_DUP;
        end else if (held_count >= LIST_SIZE) begin
          r.status = ST_FULL;
        end else begin
          held_keys[held_count] = k;
          r.position = POS_W'(held_count);
          held_count++;
        end
      end
      FN_LOOKUP: begin
        if (found) r.position = POS_W'(hit);
        else r.status = ST_NOTFOUND;
      end
      FN_REMOVE: begin
        if (found) begin
          if (remove_mode_q == REMOVE_SWAP) begin
            held_keys[hit] = held_keys[held_count - 1];
          end else begin
            for (int i = hit; i < held_count - 1; i++) held_keys[i] = held_keys[i + 1];
          end
          held_count--;
          r.position = POS_W'(hit);
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: r.status = ST_NOTFOUND;
    endcase
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k,
                               input bit typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= k;
    do @(posedge clk); while (!in_tready);
    predicted = apply_list_op(fn, k);
    expected_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  task automatic wait_list_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_remove_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    remove_mode_q = mode;
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected status %0d position %0d count %0d, got status %0d position %0d count %0d pad 'h%0h",
               $realtime, what, want.status, want.position, want.count,
               got.status, got.position, got.count,
               out_tdata[OUT_TDATA_W-1:POS_W+COUNT_W]);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[POS_W-1:0], out_tdata[POS_W+COUNT_W-1:POS_W]};
      status_seen[out_tuser]++;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got != want || out_tdata[OUT_TDATA_W-1:POS_W+COUNT_W] != '0)
          report_mismatch("result mismatch", want, got);
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int cur_mode;
    int fill_key;
    int ins_w;
    int pick;
    logic [FUNC_W-1:0] fn;
    logic [KEY_W-1:0] k;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FN_INSERT;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    requests_sent = 0;
    status_seen = '{0, 0, 0, 0};
    held_count = 0;
    remove_mode_q = REMOVE_SWAP;
    cur_mode = -1;

    steps = '{
      '{0, 0, FN_LOOKUP, 32'h0000_0000, 1, '{ST_NOTFOUND, 5'd0, 6'd0}},
      '{0, 0, FN_REMOVE, 32'h7FFF_FFFF, 1, '{ST_NOTFOUND, 5'd0, 6'd0}},
      '{0, 0, FN_UNUSED, 32'h0000_0000, 1, '{ST_NOTFOUND, 5'd0, 6'd0}},
      '{0, 0, FN_INSERT, 32'h8000_0000, 1, '{ST_OK, 5'd0, 6'd1}},
      '{0, 0, FN_INSERT, 32'h7FFF_FFFF, 1, '{ST_OK, 5'd1, 6'd2}},
      '{0, 0, FN_INSERT, 32'h0000_0000, 1, '{ST_OK, 5'd2, 6'd3}},
      '{0, 0, FN_INSERT, 32'hFFFF_FFFF, 1, '{ST_OK, 5'd3, 6'd4}},
      '{0, 0, FN_INSERT, 32'h8000_0000, 1, '{ST_DUP, 5'd0, 6'd4}},
      '{0, 0, FN_LOOKUP, 32'hFFFF_FFFF, 1, '{ST_OK, 5'd3, 6'd4}},
      '{0, 0, FN_LOOKUP, 32'h1234_5678, 1, '{ST_NOTFOUND, 5'd0, 6'd4}},
      '{0, 0, FN_UNUSED, 32'hFFFF_FFFF, 1, '{ST_NOTFOUND, 5'd0, 6'd4}},
      '{0, 0, FN_REMOVE, 32'h7FFF_FFFF, 1, '{ST_OK, 5'd1, 6'd3}},
      '{0, 0, FN_LOOKUP, 32'hFFFF_FFFF, 1, '{ST_OK, 5'd1, 6'd3}},
      '{0, 1, FN_INSERT, 32'h5555_5555, 1, '{ST_FULL, 5'd0, 6'd32}},
      '{0, 0, FN_INSERT, 32'hFFFF_FFFF, 1, '{ST_DUP, 5'd0, 6'd32}},
      '{0, 0, FN_LOOKUP, 32'h0000_101C, 0, '0},
      '{0, 0, FN_REMOVE, 32'h0000_1000, 0, '0},
      '{0, 0, FN_INSERT, 32'h5555_5555, 1, '{ST_OK, 5'd31, 6'd32}},
      '{1, 0, FN_REMOVE, 32'h8000_0000, 1, '{ST_OK, 5'd0, 6'd31}},
      '{1, 0, FN_LOOKUP, 32'hFFFF_FFFF, 1, '{ST_OK, 5'd0, 6'd31}},
      '{1, 0, FN_LOOKUP, 32'h5555_5555, 1, '{ST_OK, 5'd30, 6'd31}},
      '{1, 0, FN_REMOVE, 32'h5555_5555, 0, '0},
      '{1, 0, FN_REMOVE, 32'h0000_0001, 1, '{ST_NOTFOUND, 5'd0, 6'd30}},
      '{1, 0, FN_UNUSED, 32'h8000_0000, 1, '{ST_NOTFOUND, 5'd0, 6'd30}},
      '{1, 0, FN_LOOKUP, 32'h0000_101C, 0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].mode != cur_mode) begin
        wait_list_idle();
        write_remove_mode(steps[i].mode[0]);
        cur_mode = steps[i].mode;
      end
      if (steps[i].fill) begin
        fill_key = 32'h1000;
        while (held_count < LIST_SIZE) begin
          issue_request(FN_INSERT, fill_key, 1'b0, '0);
          fill_key++;
        end
      end
      issue_request(steps[i].func, steps[i].key, steps[i].typed, steps[i].res);
    end

    for (int phase = 0; phase < 8; phase++) begin
      wait_list_idle();
      write_remove_mode(phase[0]);
      case (phase / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      ins_w = (phase % 3 == 0) ? 60 : 38;
      foreach (key_pool[j]) key_pool[j] = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 3) fn = FN_UNUSED;
        else if (pick < 3 + ins_w) fn = FN_INSERT;
        else if (pick < 23 + ins_w) fn = FN_LOOKUP;
        else fn = FN_REMOVE;
        if ($urandom_range(9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(POOL_SIZE - 1)];
        issue_request(fn, k, 1'b0, '0);
      end
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_list_idle();
    repeat (100) @(posedge clk);

    $display("Run covered %0d requests, 25 of them directed, in both remove modes and four pacing mixes.",
             requests_sent);
    $display("Answers seen: %0d ok, %0d duplicate, %0d not found, %0d list full; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ukle_pkg.sv
design/unordered_key_list_engine.sv
tb/testbench.sv
